FILE: rtl/crct_pkg.sv
// Package for the client request counter table.
// Holds payload structs, controller/datapath command and status types and defaults.
// No dependencies.
`default_nettype none

package crct_pkg;

   localparam int DEPTH_DEFAULT     = 16;
   localparam int KEY_BYTES_DEFAULT = 29;
   localparam int CAP_W             = 5;
   localparam int COUNT_W           = 32;
   localparam int KEY_W_MAX         = 232;

   localparam logic [CAP_W-1:0]   CAP_RESET = 5'd16;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;
   localparam logic [COUNT_W-1:0] COUNT_ONE = 32'd1;

   typedef struct packed {
      logic [39:0] key_word3;
      logic [63:0] key_word2;
      logic [63:0] key_word1;
      logic [63:0] key_word0;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] hit_count;
      logic               was_hit;
      logic               evicted_oldest;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_HIT,
      ST_MISS
   } state_type;

   typedef struct packed {
      logic start;
      logic rd_en;
      logic advance;
      logic commit_hit;
      logic commit_miss;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic match;
      logic last;
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/crct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the table entry store. No dependencies.
`default_nettype none

module crct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/crct_ctrl.sv
// Controller state machine for the client request counter table.
// Sequences key capture, slot scan and commit. Depends on crct_pkg.
`default_nettype none

module crct_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire crct_pkg::status_type status,
   output crct_pkg::cmd_type         cmd
);

   crct_pkg::state_type state_ff;
   crct_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crct_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crct_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.empty ? crct_pkg::ST_MISS : crct_pkg::ST_READ;
            end
         end
         crct_pkg::ST_READ: begin
            state_in = crct_pkg::ST_CHECK;
         end
         crct_pkg::ST_CHECK: begin
            if (status.match) begin
               state_in = crct_pkg::ST_HIT;
            end else if (status.last) begin
               state_in = crct_pkg::ST_MISS;
            end else begin
               state_in = crct_pkg::ST_READ;
            end
         end
         crct_pkg::ST_HIT, crct_pkg::ST_MISS: begin
            if (!status.rsp_busy) begin
               state_in = crct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crct_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         crct_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         crct_pkg::ST_READ: begin
            cmd.rd_en = 1'b1;
         end
         crct_pkg::ST_CHECK: begin
            cmd.advance = !status.match && !status.last;
         end
         crct_pkg::ST_HIT: begin
            cmd.commit_hit = !status.rsp_busy;
         end
         crct_pkg::ST_MISS: begin
            cmd.commit_miss = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/crct_datapath.sv
// Datapath for the client request counter table: capacity register, fill and
// replacement pointers, entry RAM, key compare and response register.
// Depends on crct_pkg and crct_ram.
`default_nettype none

module crct_datapath #(
   parameter int DEPTH     = crct_pkg::DEPTH_DEFAULT,
   parameter int KEY_BYTES = crct_pkg::KEY_BYTES_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire crct_pkg::req_type           req_payload,
   input  wire logic                        csr_write_enable,
   input  wire logic [crct_pkg::CAP_W-1:0]  csr_write_data,
   input  wire crct_pkg::cmd_type           cmd,
   output crct_pkg::status_type             status,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output crct_pkg::rsp_type                rsp_payload
);

   localparam int KEY_BITS = 8 * KEY_BYTES;
   localparam int ENTRY_W  = KEY_BITS + crct_pkg::COUNT_W;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [crct_pkg::CAP_W-1:0]    cap_ff;
   logic [CNT_W-1:0]              fill_ff;
   logic [CNT_W-1:0]              fill_in;
   logic [CNT_W-1:0]              oldest_ff;
   logic [CNT_W-1:0]              oldest_in;
   logic [CNT_W-1:0]              idx_ff;
   logic [KEY_BITS-1:0]           key_ff;
   logic                          rsp_valid_ff;
   crct_pkg::rsp_type             rsp_data_ff;
   crct_pkg::rsp_type             rsp_data_in;

   logic [crct_pkg::KEY_W_MAX-1:0] req_key_flat;
   logic [CNT_W-1:0]              cap_eff;
   logic [CNT_W-1:0]              limit;
   logic [CNT_W-1:0]              victim;
   logic                          insert;
   logic [ENTRY_W-1:0]            rd_data;
   logic [KEY_BITS-1:0]           rd_key;
   logic [crct_pkg::COUNT_W-1:0]  rd_count;
   logic [crct_pkg::COUNT_W-1:0]  hit_count;
   logic                          wr_en;
   logic [CNT_W-1:0]              wr_slot;
   logic [ENTRY_W-1:0]            wr_data;

   assign req_key_flat = {req_payload.key_word3, req_payload.key_word2,
                          req_payload.key_word1, req_payload.key_word0};

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap_ff) > 32'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
      limit = (fill_ff < cap_eff) ? fill_ff : cap_eff;
   end

   assign rd_key   = rd_data[KEY_BITS-1:0];
   assign rd_count = rd_data[ENTRY_W-1:KEY_BITS];

   assign status.empty    = (limit == '0);
   assign status.match    = (rd_key == key_ff);
   assign status.last     = ({1'b0, idx_ff} + (CNT_W + 1)'(1)) >= {1'b0, limit};
   assign status.rsp_busy = rsp_valid_ff && rsp_stall;

   assign insert    = fill_ff < cap_eff;
   assign victim    = (oldest_ff < cap_eff) ? oldest_ff : '0;
   assign hit_count = (rd_count == crct_pkg::COUNT_MAX) ? rd_count
                                                        : rd_count + crct_pkg::COUNT_ONE;

   always_comb begin
      wr_en   = cmd.commit_hit || cmd.commit_miss;
      wr_slot = idx_ff;
      wr_data = {hit_count, key_ff};
      fill_in   = fill_ff;
      oldest_in = oldest_ff;
      rsp_data_in.hit_count      = hit_count;
      rsp_data_in.was_hit        = 1'b1;
      rsp_data_in.evicted_oldest = 1'b0;
      if (cmd.commit_miss) begin
         wr_data = {crct_pkg::COUNT_ONE, key_ff};
         rsp_data_in.hit_count = crct_pkg::COUNT_ONE;
         rsp_data_in.was_hit   = 1'b0;
         if (insert) begin
            wr_slot = fill_ff;
            fill_in = fill_ff + CNT_W'(1);
         end else begin
            wr_slot = victim;
            rsp_data_in.evicted_oldest = 1'b1;
            if (({1'b0, victim} + (CNT_W + 1)'(1)) >= {1'b0, cap_eff}) begin
               oldest_in = '0;
            end else begin
               oldest_in = victim + CNT_W'(1);
            end
         end
      end
   end

   crct_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_entry_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_slot[AW-1:0]),
      .wr_data(wr_data),
      .rd_en  (cmd.rd_en),
      .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= crct_pkg::CAP_RESET;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         fill_ff   <= fill_in;
         oldest_ff <= oldest_in;
         if (wr_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         key_ff <= req_key_flat[KEY_BITS-1:0];
         idx_ff <= '0;
      end else if (cmd.advance) begin
         idx_ff <= idx_ff + CNT_W'(1);
      end
      if (wr_en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

`default_nettype wire

FILE: rtl/client_request_counter_table_unit.sv
// Client request counter table: looks up client keys, counts repeat requests
// and replaces the oldest entry in insertion order when full.
// Depends on crct_pkg, crct_ctrl, crct_datapath and crct_ram.
//
// Use:
//   req_valid/req_stall/req_payload carry one client key per request.
//   rsp_valid/rsp_stall/rsp_payload return one result per request: the
//   updated count, a hit flag and an eviction flag.
//   csr_write_enable/csr_write_data set the capacity; write only while idle.
// Sequence:
//   The scan reads one entry RAM slot at a time (read, then compare), over
//   L = min(capacity, slots filled) slots, stopping at the first match;
//   capacity 0 counts as 1 and above DEPTH as DEPTH. The result is
//   registered in the hit or miss commit step (no slots are scanned on an
//   empty table), and the next request is taken after the return to idle.
// Reset:
//   The table comes up empty with capacity 16; no clearing pass is needed.
// Stall:
//   A waiting result holds in the output register while the next request is
//   accepted and scanned; that request holds in its commit step until the
//   output register frees.
`default_nettype none

module client_request_counter_table_unit #(
   parameter int DEPTH     = crct_pkg::DEPTH_DEFAULT,
   parameter int KEY_BYTES = crct_pkg::KEY_BYTES_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire crct_pkg::req_type           req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output crct_pkg::rsp_type                rsp_payload,
   input  wire logic                        csr_write_enable,
   input  wire logic [crct_pkg::CAP_W-1:0]  csr_write_data
);

   crct_pkg::cmd_type    cmd;
   crct_pkg::status_type status;

   crct_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   crct_datapath #(
      .DEPTH    (DEPTH),
      .KEY_BYTES(KEY_BYTES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_payload     (req_payload),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_payload     (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: tb/crct_count_checker.sv
// Result checker for the client request counter table: keeps its own table of keys,
// counts and insertion order, predicts every result and compares it field by field.
// Depends on crct_pkg.
module crct_count_checker
   import crct_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire req_type          req_payload,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire rsp_type          rsp_payload,
   input  wire logic             csr_write_enable,
   input  wire logic [CAP_W-1:0] csr_write_data,
   output int                    fail_count,
   output int                    pending,
   output int                    hits_seen,
   output int                    evictions_seen
);

   localparam int SLOTS = DEPTH_DEFAULT;

   req_type            slot_key [SLOTS];
   logic [COUNT_W-1:0] slot_count [SLOTS];
   logic               slot_used [SLOTS];
   int unsigned        fifo_head;
   int unsigned        fill;
   logic [CAP_W-1:0]   capacity;
   rsp_type            expected_results [$];

   function automatic rsp_type count_request(input req_type key);
      int unsigned cap;
      int unsigned slot;
      rsp_type r;
      cap = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : capacity;
      r.hit_count = COUNT_ONE;
      r.was_hit = 1'b0;
      r.evicted_oldest = 1'b0;
      for (int s = 0; s < cap; s++) begin
         if (slot_used[s] && slot_key[s] == key) begin
            if (slot_count[s] != COUNT_MAX) slot_count[s] = slot_count[s] + 1;
            r.hit_count = slot_count[s];
            r.was_hit = 1'b1;
            return r;
         end
      end
      if (fill < cap) begin
         slot = fill;
         fill++;
      end else begin
         slot = (fifo_head < cap) ? fifo_head : 0;
         fifo_head = (slot + 1 >= cap) ? 0 : slot + 1;
         r.evicted_oldest = 1'b1;
      end
      slot_key[slot] = key;
      slot_count[slot] = COUNT_ONE;
      slot_used[slot] = 1'b1;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      int errs;
      errs = 0;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) slot_used[s] = 1'b0;
         fifo_head = 0;
         fill = 0;
         capacity = CAP_RESET;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_payload.was_hit) hits_seen <= hits_seen + 1;
            if (rsp_payload.evicted_oldest) evictions_seen <= evictions_seen + 1;
            if (expected_results.size() == 0) begin
               $error("result with no request waiting: hit_count %0d", rsp_payload.hit_count);
               errs++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload.hit_count !== want.hit_count) begin
                  $error("hit_count: expected %0d, actual %0d",
                         want.hit_count, rsp_payload.hit_count);
                  errs++;
               end
               if (rsp_payload.was_hit !== want.was_hit) begin
                  $error("was_hit: expected %0b, actual %0b",
                         want.was_hit, rsp_payload.was_hit);
                  errs++;
               end
               if (rsp_payload.evicted_oldest !== want.evicted_oldest) begin
                  $error("evicted_oldest: expected %0b, actual %0b",
                         want.evicted_oldest, rsp_payload.evicted_oldest);
                  errs++;
               end
            end
         end
         if (req_valid && !req_stall) expected_results.push_back(count_request(req_payload));
         if (csr_write_enable) capacity = csr_write_data;
      end
      fail_count <= fail_count + errs;
      pending <= expected_results.size();
   end

endmodule

FILE: tb/tb_client_request_counter_table_unit.sv
// Testbench top for client_request_counter_table_unit: drives keys and capacity
// settings with random idling on both sides; crct_count_checker does the checking.
// Depends on crct_pkg, crct_count_checker and the block's RTL.
module tb_client_request_counter_table_unit;
   import crct_pkg::*;

   localparam int POOL = 20;
   localparam int PHASES = 13;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_payload;
   logic             csr_write_enable = 1'b0;
   logic [CAP_W-1:0] csr_write_data = '0;

   int   fail_count;
   int   pending;
   int   hits_seen;
   int   evictions_seen;
   logic send_gaps = 1'b0;
   logic stall_bursts = 1'b0;
   int   stall_left = 0;
   int   requests_sent = 0;
   int   settings_used = 0;

   req_type          key_pool [POOL];
   logic [CAP_W-1:0] phase_caps [PHASES] = '{5'd1, 5'd2, 5'd16, 5'd5, 5'd31, 5'd0, 5'd3,
                                              5'd8, 5'd17, 5'd4, 5'd12, 5'd7, 5'd16};

   client_request_counter_table_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   crct_count_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .hits_seen        (hits_seen),
      .evictions_seen   (evictions_seen)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (stall_bursts && $urandom_range(5, 0) == 0) begin
         stall_left <= $urandom_range(13, 0);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic req_type random_key();
      req_type k;
      logic [63:0] upper;
      k.key_word0 = {$urandom, $urandom};
      k.key_word1 = {$urandom, $urandom};
      k.key_word2 = {$urandom, $urandom};
      upper = {$urandom, $urandom};
      k.key_word3 = upper[39:0];
      return k;
   endfunction

   task automatic send_request(input req_type key);
      req_valid <= 1'b1;
      req_payload <= key;
      do begin
         @(posedge clock);
      end while (req_stall);
      requests_sent++;
      if (send_gaps && $urandom_range(3, 0) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(14, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] value);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   initial begin
      req_type     k;
      int unsigned active;
      int unsigned pool_size;
      int unsigned pick;
      int unsigned flip;
      int          phase_len;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request('0);
      send_request('0);
      send_request('1);
      k = '1;
      k[KEY_W_MAX-1] = 1'b0;
      send_request(k);
      send_request('1);
      k = '0;
      k.key_word1[63] = 1'b1;
      send_request(k);
      k = '0;
      k.key_word2[0] = 1'b1;
      send_request(k);
      k = '0;
      k.key_word3[39] = 1'b1;
      send_request(k);

      set_capacity(5'd0);
      send_request('1);
      send_request('1);
      send_request('0);

      set_capacity(5'd31);
      repeat (12) send_request(random_key());

      for (int i = 0; i < POOL; i++) key_pool[i] = random_key();

      for (int p = 0; p < PHASES; p++) begin
         set_capacity(phase_caps[p]);
         send_gaps <= (p != PHASES - 1) && $urandom_range(3, 0) != 0;
         stall_bursts <= (p != PHASES - 1) && $urandom_range(3, 0) != 0;
         active = (phase_caps[p] == 0) ? 1 : (phase_caps[p] > DEPTH_DEFAULT) ? DEPTH_DEFAULT
                                                                            : phase_caps[p];
         pool_size = active + $urandom_range(4, 0);
         key_pool[$urandom_range(POOL - 1, 0)] = random_key();
         key_pool[$urandom_range(POOL - 1, 0)] = random_key();
         phase_len = (p == PHASES - 1) ? 200 : 120;
         for (int n = 0; n < phase_len; n++) begin
            pick = $urandom_range(19, 0);
            k = key_pool[$urandom_range(pool_size - 1, 0)];
            if (pick == 0) begin
               k = random_key();
            end else if (pick == 1) begin
               flip = $urandom_range(KEY_W_MAX - 1, 0);
               k[flip] = ~k[flip];
            end
            send_request(k);
            // drain mid-phase with the sender held off
            if (p == 6 && n == 60) wait_for_results();
         end
      end

      wait_for_results();
      repeat (40) @(posedge clock);
      $display("Sent %0d requests over %0d capacity settings, from 0 up to 31.",
               requests_sent, settings_used);
      $display("Results included %0d hits and %0d oldest-entry replacements.",
               hits_seen, evictions_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_client_request_counter_table_unit OK");
      end else begin
         $display("tb_client_request_counter_table_unit NOT OK");
      end
      $finish;
   end

   initial begin
      #(12 * 800000);
      $display("tb_client_request_counter_table_unit NOT OK");
      $finish;
   end

endmodule

FILE: sim.f
rtl/crct_pkg.sv
rtl/crct_ram.sv
rtl/crct_ctrl.sv
rtl/crct_datapath.sv
rtl/client_request_counter_table_unit.sv
tb/crct_count_checker.sv
tb/tb_client_request_counter_table_unit.sv
